@@ sv/bf3_pkg.sv @@
package bf3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W   = 8;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int CFG_WW  = 11;
	localparam int CFG_HW  = 13;
	localparam int CFG_DW  = 13;
	localparam int CFG_IW  = 1;
	localparam int SUM_W   = 12;
	localparam int OUT_DW  = 32;

	// floor(sum / 9) == (sum * 3641) >> 15 for every sum below 32768
	localparam int RECIP_W     = 12;
	localparam int RECIP       = 3641;
	localparam int RECIP_SHIFT = 15;

	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [SUM_W-1:0] sum_t;

	// Per-item tag that rides along the pipeline
	typedef struct packed {
		logic emit;
		logic last;
		col_t cx;
		row_t cy;
	} tag_t;

endpackage

@@ sv/bf3_line_buf.sv @@
module bf3_line_buf (
	input  logic                 clk,
	input  logic                 rd_en,
	input  bf3_pkg::col_t        rd_addr,
	input  bf3_pkg::pix_t        wr_pix,
	input  logic                 wb_en,
	input  bf3_pkg::col_t        wb_addr,
	output bf3_pkg::pix_t        top,
	output bf3_pkg::pix_t        mid
);
	import bf3_pkg::*;

	pix_t mem_a [MAX_WIDTH];
	pix_t mem_b [MAX_WIDTH];
	pix_t mid_q;
	pix_t top_q;

	// Row y-1: read old value, write the new pixel at the same column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_q <= mem_a[rd_addr];
			mem_a[rd_addr] <= wr_pix;
		end
	end

	// Row y-2: receives what row y-1 held, written back as stage 1 moves on
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_q <= mem_b[rd_addr];
		end
		if (wb_en) begin
			mem_b[wb_addr] <= mid_q;
		end
	end

	assign top = top_q;
	assign mid = mid_q;

endmodule

@@ sv/box_filter_3x3.sv @@
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata[7:0] pixel_in
// m_*       out  m_tvalid / m_tready    m_tdata filtered_value, centre_x, centre_y; m_tlast
// cfg_*     in   cfg_valid / cfg_ready  cfg_index (0 width, 1 height), cfg_data
//
// One pixel per clock sustained unless the output stalls; m_tvalid rises once the input
// transaction has passed the line store read on the accepting edge, the window shift, the
// adder tree and the reciprocal multiply into the output register.
// Line stores have no reset; the user must only read them after the row above was written,
// as the block does not enforce it. Window, counters and pipeline valid bits clear on arst_n.
// The pipeline stalls only when a result would land on an output register still held
// by m_tready low; items without a result keep flowing under backpressure.
module box_filter_3x3 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bf3_pkg::PIX_W-1:0]   s_tdata,   // [7:0] pixel_in
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bf3_pkg::OUT_DW-1:0]  m_tdata,   // [7:0] filtered_value, [17:8] centre_x,
	                                               // [29:18] centre_y, [31:30] zero
	output logic                        m_tlast,   // frame_last
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bf3_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [bf3_pkg::CFG_DW-1:0]  cfg_data
);
	import bf3_pkg::*;

	logic [CFG_WW-1:0] width_q;
	logic [CFG_HW-1:0] height_q;
	logic [CFG_WW-1:0] wm1;
	logic [CFG_HW-1:0] hm1;

	col_t col_q;
	row_t row_q;
	logic end_line;
	logic end_frame;
	logic acc;
	logic adv;
	logic load_out;

	// stage 1: line store read in flight
	logic v_s1;
	pix_t pix_s1;
	col_t addr_s1;
	tag_t tag_s1;
	pix_t top;
	pix_t mid;

	// stage 2: window holds the neighbourhood of this item
	logic v_s2;
	tag_t tag_s2;
	pix_t win_q [9];

	// stage 3: neighbourhood sum
	logic v_s3;
	tag_t tag_s3;
	sum_t sum_s3;

	logic [SUM_W-1:0] row0_sum;
	logic [SUM_W-1:0] row1_sum;
	logic [SUM_W-1:0] row2_sum;
	logic [SUM_W+RECIP_W-1:0] prod;

	pix_t fval_q;
	col_t cx_q;
	row_t cy_q;
	logic last_q;

	// Configuration: always ready, takes effect at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_WW'(MAX_WIDTH);
			height_q <= CFG_HW'(1024);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_WW-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[CFG_HW-1:0];
				default: ;
			endcase
		end
	end

	// Clamp to [3, MAX] and take the last index of a line and a frame
	always_comb begin
		if (width_q < CFG_WW'(3)) begin
			wm1 = CFG_WW'(2);
		end else if (width_q > CFG_WW'(MAX_WIDTH)) begin
			wm1 = CFG_WW'(MAX_WIDTH - 1);
		end else begin
			wm1 = width_q - CFG_WW'(1);
		end
		if (height_q < CFG_HW'(3)) begin
			hm1 = CFG_HW'(2);
		end else if (height_q > CFG_HW'(MAX_HEIGHT)) begin
			hm1 = CFG_HW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = height_q - CFG_HW'(1);
		end
	end

	// A counter at or past the limit counts as the end, so it wraps on the next pixel
	assign end_line  = CFG_WW'(col_q) >= wm1;
	assign end_frame = end_line && (CFG_HW'(row_q) >= hm1);

	// Hold the whole pipeline only when a result would overwrite a waiting one
	assign load_out = v_s3 && tag_s3.emit;
	assign adv      = !(load_out && m_tvalid && !m_tready);
	assign s_tready = adv;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (end_frame) begin
				col_q <= '0;
				row_q <= '0;
			end else if (end_line) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage 1 capture; the line store read happens on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1      <= s_tdata;
			addr_s1     <= col_q;
			tag_s1.emit <= (col_q >= col_t'(2)) && (row_q >= row_t'(2));
			tag_s1.last <= end_frame;
			tag_s1.cx   <= col_q - col_t'(1);
			tag_s1.cy   <= row_q - row_t'(1);
		end
	end

	// Row y-2 takes row y-1's old pixel as stage 1 moves on
	bf3_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.wr_pix  (s_tdata),
		.wb_en   (v_s1 && adv),
		.wb_addr (addr_s1),
		.top     (top),
		.mid     (mid)
	);

	// Shift the window left and insert the new column (oldest row at the top)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1 && adv) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= top;
			win_q[5] <= mid;
			win_q[8] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Adder tree over the window: three row sums, then the total
	assign row0_sum = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2]);
	assign row1_sum = SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);
	assign row2_sum = SUM_W'(win_q[6]) + SUM_W'(win_q[7]) + SUM_W'(win_q[8]);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			sum_s3 <= row0_sum + row1_sum + row2_sum;
		end
	end

	// Divide by nine through the reciprocal
	assign prod = (SUM_W+RECIP_W)'(sum_s3) * (SUM_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out && adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && adv) begin
			fval_q <= prod[RECIP_SHIFT +: PIX_W];
			cx_q   <= tag_s3.cx;
			cy_q   <= tag_s3.cy;
			last_q <= tag_s3.last;
		end
	end

	assign m_tdata = {(OUT_DW-PIX_W-COL_W-ROW_W)'(0), cy_q, cx_q, fval_q};
	assign m_tlast = last_q;

endmodule

@@ sv/bf3_checker.sv @@
module bf3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bf3_pkg::OUT_DW-1:0]  m_tdata,
	input logic                        m_tlast,
	input logic                        cfg_ready
);
	import bf3_pkg::*;

	// A held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Input only stalls behind a result that is not being taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// Centre coordinates never sit on the top or left border
	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[PIX_W +: COL_W] != '0 && m_tdata[PIX_W+COL_W +: ROW_W] != '0)
		else $error("centre on border");

	// Padding bits above centre_y stay zero, config port never blocks
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DW-1 -: 2] == 2'b00 && cfg_ready)
		else $error("padding set or config blocked");

endmodule

bind box_filter_3x3 bf3_checker u_bf3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);

@@ verif/box_filter_3x3_checker.sv @@
module box_filter_3x3_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  bf3_pkg::pix_t              s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [bf3_pkg::OUT_DW-1:0] m_tdata,
	input  logic                       m_tlast,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [bf3_pkg::CFG_IW-1:0] cfg_index,
	input  logic [bf3_pkg::CFG_DW-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         frame_left,
	output logic                       frame_fresh
);
	import bf3_pkg::*;

	typedef struct packed {
		pix_t mean;
		col_t cx;
		row_t cy;
		logic last;
	} mean_result_t;

	mean_result_t      mean_q[$];
	pix_t              line_prev [MAX_WIDTH];
	pix_t              line_prev2[MAX_WIDTH];
	pix_t              win[9];
	logic [CFG_WW-1:0] width_reg;
	logic [CFG_HW-1:0] height_reg;
	int                col_pos;
	int                row_pos;

	function automatic int clamp_dim(int v, int hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Pixels still needed to reach the next frame wrap
	function automatic int pixels_to_frame_end();
		int w;
		int h;
		int line_rest;
		int rows_rest;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		line_rest = (col_pos >= w - 1) ? 1 : w - col_pos;
		rows_rest = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
		return line_rest + rows_rest * w;
	endfunction

	function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
		if (got === want)
			return 1'b1;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1'b0;
	endfunction

	task automatic slide_window(input pix_t pix);
		int           w;
		int           h;
		int           sum;
		int           i;
		pix_t         top;
		pix_t         mid;
		logic         eol;
		logic         eof;
		mean_result_t r;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		eol = col_pos >= w - 1;
		eof = eol && row_pos >= h - 1;
		top = line_prev2[col_pos];
		mid = line_prev[col_pos];
		line_prev2[col_pos] = mid;
		line_prev[col_pos] = pix;
		for (i = 0; i < 3; i++) begin
			win[i*3]   = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = pix;
		if (col_pos >= 2 && row_pos >= 2) begin
			sum = 0;
			for (i = 0; i < 9; i++)
				sum += win[i];
			r.mean = pix_t'(sum / 9);
			r.cx   = col_t'(col_pos - 1);
			r.cy   = row_t'(row_pos - 1);
			r.last = eof;
			mean_q.push_back(r);
		end
		if (eof) begin
			col_pos = 0;
			row_pos = 0;
		end else if (eol) begin
			col_pos = 0;
			row_pos = row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	task automatic check_result();
		mean_result_t e;
		if (mean_q.size() == 0) begin
			$display("%0t: unexpected result, expected none got %0d at (%0d,%0d)",
				$time, m_tdata[7:0], m_tdata[17:8], m_tdata[29:18]);
			fail_count++;
		end else begin
			e = mean_q.pop_front();
			if (!field_ok("filtered_value", e.mean, m_tdata[7:0]))
				fail_count++;
			if (!field_ok("centre_x", e.cx, m_tdata[17:8]))
				fail_count++;
			if (!field_ok("centre_y", e.cy, m_tdata[29:18]))
				fail_count++;
			if (!field_ok("tdata padding", 0, m_tdata[31:30]))
				fail_count++;
			if (!field_ok("frame_last", e.last, m_tlast))
				fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				line_prev[i]  = '0;
				line_prev2[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			mean_q.delete();
			width_reg   = CFG_WW'(1024);
			height_reg  = CFG_HW'(1024);
			col_pos     = 0;
			row_pos     = 0;
			fail_count  = 0;
			pending     <= 0;
			frame_left  <= 1024 * 1024;
			frame_fresh <= 1'b1;
		end else begin
			// results leave from older pixels, so check before taking the new one
			if (m_tvalid && m_tready)
				check_result();
			// a pixel taken on the same edge as a register write still sees the old value
			if (s_tvalid && s_tready)
				slide_window(s_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg = cfg_data[CFG_WW-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[CFG_HW-1:0];
					default: ;
				endcase
			end
			pending     <= mean_q.size();
			frame_left  <= pixels_to_frame_end();
			frame_fresh <= (col_pos == 0) && (row_pos == 0);
		end
	end

endmodule

@@ verif/box_filter_3x3_tb.sv @@
module box_filter_3x3_tb;
	import bf3_pkg::*;

	// Pacing of the two stream sides, stepped through as the run advances
	typedef enum int {
		PACE_SENDER_LIGHT,  // sender idles 30 %, receiver 76 %
		PACE_SENDER_HEAVY,  // sender idles 76 %, receiver 30 %
		PACE_FULL           // nobody idles
	} pace_t;

	localparam int ITEM_TARGET   = 1650;
	localparam int SETTLE_CYCLES = 8;    // drain time for pixels that make no result
	localparam int LONG_HOLD     = 250;  // receiver hold-off, in cycles
	localparam int PRESS_W       = 8;
	localparam int PRESS_H       = 12;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	pix_t              s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic              m_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DW-1:0] cfg_data  = '0;

	int                fail_count;
	int                pending;
	int                frame_left;
	logic              frame_fresh;

	pace_t             pace            = PACE_SENDER_LIGHT;
	logic              sink_hold_req   = 1'b0;
	logic              sink_hold_used  = 1'b0;
	int                sink_hold_left  = 0;
	int                items_sent      = 0;
	int                cur_w           = 1024;
	int                cur_h           = 1024;

	always #5 clk = ~clk;

	box_filter_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predict and compare every transaction on the three channels
	box_filter_3x3_checker mean_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.frame_left  (frame_left),
		.frame_fresh (frame_fresh)
	);

	// Receiver: one long hold-off on request, otherwise random stalls per pace
	always @(posedge clk) begin
		if (sink_hold_req && !sink_hold_used) begin
			sink_hold_used <= 1'b1;
			sink_hold_left <= LONG_HOLD;
			m_tready       <= 1'b0;
		end else if (sink_hold_left > 0) begin
			sink_hold_left <= sink_hold_left - 1;
			m_tready       <= 1'b0;
		end else begin
			case (pace)
				PACE_SENDER_LIGHT: m_tready <= $urandom_range(0, 99) >= 76;
				PACE_SENDER_HEAVY: m_tready <= $urandom_range(0, 99) >= 30;
				default:           m_tready <= 1'b1;
			endcase
		end
	end

	function automatic int eff_dim(int raw, int hi);
		if (raw < 3)
			return 3;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// Height for a new setting: mostly small, sometimes clamped low or high, or tall
	function automatic logic [CFG_DW-1:0] pick_height();
		case ($urandom_range(0, 19))
			0:       return CFG_DW'($urandom_range(0, 2));
			1:       return CFG_DW'($urandom_range(MAX_HEIGHT + 1, 8191));
			2:       return CFG_DW'($urandom_range(20, MAX_HEIGHT));
			default: return CFG_DW'($urandom_range(3, 10));
		endcase
	endfunction

	// Offer one pixel, idling first as the pace says, and hold until the transaction
	task automatic send_pixel(input pix_t p);
		int idle_pct;
		idle_pct = (pace == PACE_SENDER_LIGHT) ? 30 : (pace == PACE_SENDER_HEAVY) ? 76 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		if (items_sent >= 2 * ITEM_TARGET / 3)
			pace <= PACE_FULL;
		else if (items_sent >= ITEM_TARGET / 3)
			pace <= PACE_SENDER_HEAVY;
	endtask

	// Write width and/or height back to back; lower valid once at the end
	task automatic write_regs(input logic do_w, input logic [CFG_DW-1:0] w_val,
	                          input logic do_h, input logic [CFG_DW-1:0] h_val);
		if (do_w) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data  <= w_val;
			do
				@(posedge clk);
			while (!cfg_ready);
			cur_w = eff_dim(w_val[CFG_WW-1:0], MAX_WIDTH);
		end
		if (do_h) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data  <= h_val;
			do
				@(posedge clk);
			while (!cfg_ready);
			cur_h = eff_dim(h_val[CFG_HW-1:0], MAX_HEIGHT);
		end
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every expected result, then let pixels that
	// make no result drain out of the pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int   count;
		int   sel;
		int   n;
		bit   pressed;
		logic [CFG_DW-1:0] w_val;

		pressed = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frame 1: widest clamped width and tallest clamped height, all-white pixels.
		// Shrink both mid-line: the column counter is already past the new
		// width, so the next pixel ends the row, and the frame ends at row 2.
		write_regs(1'b1, CFG_DW'(2047), 1'b1, CFG_DW'(8191));
		repeat (4) send_pixel(8'hFF);
		settle();
		write_regs(1'b1, CFG_DW'(0), 1'b1, CFG_DW'(0));
		repeat (7) send_pixel(8'hFF);
		settle();

		// Frame 2: zero mean first, then random content; cut the height while
		// the row counter is already past it so the frame ends on that row
		write_regs(1'b0, '0, 1'b1, CFG_DW'(8191));
		for (n = 0; n < 12; n++)
			send_pixel(n < 9 ? 8'h00 : pix_t'($urandom_range(0, 255)));
		settle();
		write_regs(1'b0, '0, 1'b1, CFG_DW'(3));
		repeat (3) send_pixel(pix_t'($urandom_range(0, 255)));

		// Random phases, each entered with the block idle
		while (items_sent < ITEM_TARGET) begin
			settle();
			if (!pressed && items_sent >= 400 && frame_fresh) begin
				// Hold the receiver off while a full frame is pushed in, so the
				// output fills and the input stalls
				pressed = 1'b1;
				write_regs(1'b1, CFG_DW'(PRESS_W), 1'b1, CFG_DW'(PRESS_H));
				sink_hold_req <= 1'b1;
				repeat (PRESS_W * PRESS_H) send_pixel(pix_t'($urandom_range(0, 255)));
				sink_hold_req <= 1'b0;
				continue;
			end
			if (frame_fresh) begin
				// Any width may be set at a frame start; the line stores refill
				// before the first row that reads them
				case ($urandom_range(0, 19))
					0:       w_val = CFG_DW'($urandom_range(0, 2));
					1:       w_val = CFG_DW'($urandom_range(MAX_WIDTH + 1, 2047));
					2:       w_val = CFG_DW'($urandom_range(100, MAX_WIDTH));
					default: w_val = CFG_DW'($urandom_range(3, 24));
				endcase
				w_val[CFG_DW-1:CFG_WW] = 2'($urandom_range(0, 3));
				write_regs(1'b1, w_val, 1'b1, pick_height());
				if (cur_w * cur_h <= 200)
					count = cur_w * cur_h * $urandom_range(1, 2);
				else
					count = $urandom_range(1, 120);
			end else if (frame_left <= 600 && $urandom_range(0, 1)) begin
				// Finish the frame as set
				count = frame_left;
			end else begin
				// Mid-frame: any height, but the width only shrinks so no
				// unwritten line store entry is ever read
				sel = $urandom_range(0, 2);
				w_val = CFG_DW'($urandom_range(0, cur_w));
				w_val[CFG_DW-1:CFG_WW] = 2'($urandom_range(0, 3));
				write_regs(sel != 1, w_val, sel != 0, pick_height());
				count = $urandom_range(1, 60);
			end
			repeat (count) send_pixel(pix_t'($urandom_range(0, 255)));
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Timeout
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
